// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the touch tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, switched off while rst_n is low.
`define TST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/tst_pkg.sv
// Types and constants of the two-slot touch tracker.
package tst_pkg;

  localparam int COORD_W   = 12;
  localparam int ID_W      = 4;
  localparam int Z_W       = 8;
  localparam int MAJOR_W   = Z_W - 1;
  localparam int CNT_W     = 2;
  localparam int TRACK_IDS = 16;

  localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

  localparam logic MODE_PER_SLOT = 1'b0;
  localparam logic MODE_FIXED    = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]   prev_count;
    logic [CNT_W-1:0]   cur_count;
    logic [ID_W-1:0]    id_first;
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] y_first;
    logic [Z_W-1:0]     z_first;
    logic [ID_W-1:0]    id_second;
    logic [COORD_W-1:0] x_second;
    logic [COORD_W-1:0] y_second;
    logic [Z_W-1:0]     z_second;
  } frame_t;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [Z_W-1:0]     z;
  } slot_t;

  typedef slot_t [1:0] slot_pair_t;

  typedef struct packed {
    logic               slot_index;
    logic               has_contact;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [MAJOR_W-1:0] major;
    logic               buttons_present;
    logic               button_touch;
    logic               button_second;
    logic               last;
  } rec_t;

  typedef struct packed {
    rec_t first;
    rec_t second;
    logic two;
  } frame_recs_t;

endpackage

// File: hw/rtl/tst_if.sv
// Channel interfaces of the two-slot touch tracker.
interface tst_in_if import tst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   prev_count;
  logic [CNT_W-1:0]   cur_count;
  logic [ID_W-1:0]    id_first;
  logic [COORD_W-1:0] x_first;
  logic [COORD_W-1:0] y_first;
  logic [Z_W-1:0]     z_first;
  logic [ID_W-1:0]    id_second;
  logic [COORD_W-1:0] x_second;
  logic [COORD_W-1:0] y_second;
  logic [Z_W-1:0]     z_second;

  modport source (
    output valid, prev_count, cur_count, id_first, x_first, y_first, z_first,
           id_second, x_second, y_second, z_second,
    input  ready
  );
  modport sink (
    input  valid, prev_count, cur_count, id_first, x_first, y_first, z_first,
           id_second, x_second, y_second, z_second,
    output ready
  );
endinterface

interface tst_out_if import tst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               slot_index;
  logic               has_contact;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [MAJOR_W-1:0] major;
  logic               buttons_present;
  logic               button_touch;
  logic               button_second;
  logic               last;

  modport source (
    output valid, slot_index, has_contact, pos_x, pos_y, major, buttons_present,
           button_touch, button_second, last,
    input  ready
  );
  modport sink (
    input  valid, slot_index, has_contact, pos_x, pos_y, major, buttons_present,
           button_touch, button_second, last,
    output ready
  );
endinterface

interface tst_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/two_slot_touch_tracker_unit.sv
// Top level of the two-slot touch tracker.
// Usage: one touch frame per transaction on in_ch (prev/cur contact counts and
// up to two contacts). The block keeps two slots and emits one or two records
// per frame on out_ch; the record with last set closes the frame.
// cfg_ch writes the one-bit report mode and is always ready; the user must write
// it only while no frame is in flight, which the block does not enforce. Mode 0
// reports each valid slot, or one empty record; mode 1 always reports slot 0 with
// button states, then slot 1 if valid.
// An input register feeds the slot update logic, whose records land in a
// two-entry result buffer; the slot registers update in the same cycle.
// Throughput: one record per cycle while out_ch is ready, set by the result port;
// a frame loads into the buffer as the last record of the frame before is taken.
// When out_ch stalls, the buffer holds its records and the input register holds
// the next frame; in_ch.ready drops only while both are occupied.
// Reset clears both slots (invalid, id, position and pressure zero), the report
// mode and all valid flags.
`include "assert_macros.svh"

module two_slot_touch_tracker_unit import tst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tst_in_if.sink     in_ch,
  tst_out_if.source  out_ch,
  tst_cfg_if.sink    cfg_ch
);

  logic        in_v_r;
  logic        in_v_nxt;
  frame_t      frame_r;
  logic        mode_r;
  logic        load;
  logic        can_load;
  logic        in_take;
  frame_recs_t recs;

  assign load         = in_v_r && can_load;
  assign in_ch.ready  = !in_v_r || load;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    in_v_nxt = in_v_r;
    if (load) begin
      in_v_nxt = 1'b0;
    end
    if (in_take) begin
      in_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      mode_r <= MODE_PER_SLOT;
    end else begin
      in_v_r <= in_v_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        mode_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      frame_r.prev_count <= in_ch.prev_count;
      frame_r.cur_count  <= in_ch.cur_count;
      frame_r.id_first   <= in_ch.id_first;
      frame_r.x_first    <= in_ch.x_first;
      frame_r.y_first    <= in_ch.y_first;
      frame_r.z_first    <= in_ch.z_first;
      frame_r.id_second  <= in_ch.id_second;
      frame_r.x_second   <= in_ch.x_second;
      frame_r.y_second   <= in_ch.y_second;
      frame_r.z_second   <= in_ch.z_second;
    end
  end

  tst_slot_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .mode  (mode_r),
    .frame (frame_r),
    .recs  (recs)
  );

  tst_rec_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .recs     (recs),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  `TST_ASSERT(a_frame_held, (in_v_r && !load) |=> in_v_r, "stalled frame dropped from input register")

endmodule

// File: hw/rtl/tst_slot_core.sv
// Slot state registers, per-frame slot update and record formation.
`include "assert_macros.svh"

module tst_slot_core import tst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic        mode,
  input  frame_t      frame,
  output frame_recs_t recs
);

  slot_pair_t slots_r;
  slot_pair_t slots_nxt;
  logic       free_en;
  logic       v0;
  logic       v1;
  rec_t       rec_s0_per;
  rec_t       rec_s0_fix;
  rec_t       rec_s1;
  rec_t       rec_empty;

  function automatic slot_pair_t place_contact(slot_pair_t s, logic [ID_W-1:0] id,
                                               logic [COORD_W-1:0] x,
                                               logic [COORD_W-1:0] y,
                                               logic [Z_W-1:0] z);
    slot_pair_t r;
    logic       sel;
    r = s;
    if (s[0].valid && s[0].id == id) begin
      sel = 1'b0;
    end else if (s[1].valid && s[1].id == id) begin
      sel = 1'b1;
    end else if (!s[0].valid) begin
      sel = 1'b0;
    end else begin
      sel = 1'b1;
    end
    r[sel].id    = id;
    r[sel].x     = x;
    r[sel].y     = y;
    r[sel].z     = z;
    r[sel].valid = (int'(id) < TRACK_IDS);
    return r;
  endfunction

  assign free_en = (frame.cur_count != CNT_ZERO) &&
                   (frame.prev_count == CNT_ONE || frame.prev_count == CNT_TWO);

  always_comb begin
    slots_nxt = slots_r;
    if (free_en) begin
      if (frame.prev_count == CNT_TWO && slots_nxt[1].valid &&
          slots_nxt[1].id != frame.id_first && slots_nxt[1].id != frame.id_second) begin
        slots_nxt[1].valid = 1'b0;
      end
      if (slots_nxt[0].valid && slots_nxt[0].id != frame.id_first &&
          slots_nxt[0].id != frame.id_second) begin
        slots_nxt[0].valid = 1'b0;
      end
    end
    if (frame.cur_count == CNT_TWO) begin
      slots_nxt = place_contact(slots_nxt, frame.id_second, frame.x_second,
                                frame.y_second, frame.z_second);
    end
    if (frame.cur_count == CNT_ONE || frame.cur_count == CNT_TWO) begin
      slots_nxt = place_contact(slots_nxt, frame.id_first, frame.x_first,
                                frame.y_first, frame.z_first);
    end
    if (frame.cur_count == CNT_ZERO) begin
      slots_nxt[0].valid = 1'b0;
      slots_nxt[1].valid = 1'b0;
    end
  end

  assign v0 = slots_nxt[0].valid;
  assign v1 = slots_nxt[1].valid;

  always_comb begin
    rec_s0_per.slot_index      = 1'b0;
    rec_s0_per.has_contact     = 1'b1;
    rec_s0_per.pos_x           = slots_nxt[0].x;
    rec_s0_per.pos_y           = slots_nxt[0].y;
    rec_s0_per.major           = slots_nxt[0].z[Z_W-1:1];
    rec_s0_per.buttons_present = 1'b1;
    rec_s0_per.button_touch    = 1'b1;
    rec_s0_per.button_second   = 1'b1;
    rec_s0_per.last            = 1'b0;

    rec_s0_fix              = rec_s0_per;
    rec_s0_fix.major        = v0 ? slots_nxt[0].z[Z_W-1:1] : '0;
    rec_s0_fix.button_touch = v0;
    rec_s0_fix.button_second = v1;

    rec_s1.slot_index      = 1'b1;
    rec_s1.has_contact     = 1'b1;
    rec_s1.pos_x           = slots_nxt[1].x;
    rec_s1.pos_y           = slots_nxt[1].y;
    rec_s1.major           = slots_nxt[1].z[Z_W-1:1];
    rec_s1.buttons_present = 1'b0;
    rec_s1.button_touch    = 1'b0;
    rec_s1.button_second   = 1'b0;
    rec_s1.last            = 1'b0;

    rec_empty = '0;
  end

  always_comb begin
    recs.second = rec_s1;
    recs.two    = 1'b0;
    case (mode)
      MODE_FIXED: begin
        recs.first = rec_s0_fix;
        recs.two   = v1;
      end
      MODE_PER_SLOT: begin
        if (v0) begin
          recs.first = rec_s0_per;
          recs.two   = v1;
        end else if (v1) begin
          recs.first = rec_s1;
        end else begin
          recs.first = rec_empty;
        end
      end
      default: begin
        recs.first = rec_empty;
      end
    endcase
    recs.first.last  = !recs.two;
    recs.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= '0;
    end else if (load) begin
      slots_r <= slots_nxt;
    end
  end

  `TST_ASSERT(a_zero_count_frees, (load && frame.cur_count == CNT_ZERO) |=> (!slots_r[0].valid && !slots_r[1].valid), "zero contact count left a slot valid")
  `TST_ASSERT(a_fixed_two_recs, (mode == MODE_FIXED) |-> (recs.two == v1), "fixed mode record count does not follow slot 1")

endmodule

// File: hw/rtl/tst_rec_buf.sv
// Two-entry result buffer that hands out the records of one frame in order.
`include "assert_macros.svh"

module tst_rec_buf import tst_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  frame_recs_t   recs,
  output logic          can_load,
  tst_out_if.source     out_ch
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  rec_t       a_r;
  rec_t       a_nxt;
  rec_t       b_r;
  rec_t       b_nxt;
  logic       pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign can_load = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_comb begin
    cnt_nxt = cnt_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      a_nxt   = b_r;
    end
    if (load) begin
      a_nxt   = recs.first;
      b_nxt   = recs.second;
      cnt_nxt = recs.two ? 2'd2 : 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign out_ch.valid           = (cnt_r != 2'd0);
  assign out_ch.slot_index      = a_r.slot_index;
  assign out_ch.has_contact     = a_r.has_contact;
  assign out_ch.pos_x           = a_r.pos_x;
  assign out_ch.pos_y           = a_r.pos_y;
  assign out_ch.major           = a_r.major;
  assign out_ch.buttons_present = a_r.buttons_present;
  assign out_ch.button_touch    = a_r.button_touch;
  assign out_ch.button_second   = a_r.button_second;
  assign out_ch.last            = a_r.last;

  `TST_ASSERT(a_cnt_range, cnt_r != 2'd3, "record buffer count out of range")
  `TST_ASSERT(a_load_space, load |-> can_load, "frame loaded into a full record buffer")
  `TST_ASSERT(a_last_closes, (out_ch.valid && cnt_r == 2'd1) |-> a_r.last, "final buffered record not marked last")

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the two-slot touch tracker: directed and random frames.
`timescale 1ns / 1ps

module tb_top;
  import tst_pkg::*;

  localparam logic [CNT_W-1:0] CNT_BAD = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_FRAMES = 228;

  logic clk;
  logic rst_n;

  tst_in_if  in_ch ();
  tst_out_if out_ch ();
  tst_cfg_if cfg_ch ();

  two_slot_touch_tracker_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  slot_t            track_slots [2];
  logic             report_mode_q;
  rec_t             expected_recs [$];
  int               mismatches;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_len;
  logic [CNT_W-1:0] gen_count;
  logic [ID_W-1:0]  gen_ids [2];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic frame_t mk_frame(
    input logic [CNT_W-1:0]   prev, input logic [CNT_W-1:0] cur,
    input logic [ID_W-1:0]    id0,  input logic [COORD_W-1:0] x0,
    input logic [COORD_W-1:0] y0,   input logic [Z_W-1:0] z0,
    input logic [ID_W-1:0]    id1,  input logic [COORD_W-1:0] x1,
    input logic [COORD_W-1:0] y1,   input logic [Z_W-1:0] z1);
    frame_t f;
    f.prev_count = prev;
    f.cur_count  = cur;
    f.id_first   = id0;
    f.x_first    = x0;
    f.y_first    = y0;
    f.z_first    = z0;
    f.id_second  = id1;
    f.x_second   = x1;
    f.y_second   = y1;
    f.z_second   = z1;
    return f;
  endfunction

  function automatic rec_t make_rec(
    input logic idx, input logic has, input logic [COORD_W-1:0] x,
    input logic [COORD_W-1:0] y, input logic [MAJOR_W-1:0] maj,
    input logic bp, input logic b_touch, input logic b_second);
    rec_t r;
    r.slot_index      = idx;
    r.has_contact     = has;
    r.pos_x           = x;
    r.pos_y           = y;
    r.major           = maj;
    r.buttons_present = bp;
    r.button_touch    = b_touch;
    r.button_second   = b_second;
    r.last            = 1'b0;
    return r;
  endfunction

  function automatic void place_contact(
    input logic [ID_W-1:0] id, input logic [COORD_W-1:0] x,
    input logic [COORD_W-1:0] y, input logic [Z_W-1:0] z);
    logic s;
    if (track_slots[0].valid && track_slots[0].id == id) begin
      s = 1'b0;
    end else if (track_slots[1].valid && track_slots[1].id == id) begin
      s = 1'b1;
    end else if (!track_slots[0].valid) begin
      s = 1'b0;
    end else begin
      s = 1'b1;
    end
    track_slots[s].id    = id;
    track_slots[s].x     = x;
    track_slots[s].y     = y;
    track_slots[s].z     = z;
    track_slots[s].valid = (int'(id) < TRACK_IDS);
  endfunction

  function automatic void predict_frame(input frame_t f);
    rec_t r0;
    rec_t r1;
    logic has_two;
    if ((f.prev_count == CNT_ONE || f.prev_count == CNT_TWO) && f.cur_count != CNT_ZERO) begin
      if (f.prev_count == CNT_TWO && track_slots[1].valid &&
          track_slots[1].id != f.id_first && track_slots[1].id != f.id_second)
        track_slots[1].valid = 1'b0;
      if (track_slots[0].valid &&
          track_slots[0].id != f.id_first && track_slots[0].id != f.id_second)
        track_slots[0].valid = 1'b0;
    end
    if (f.cur_count == CNT_TWO)
      place_contact(f.id_second, f.x_second, f.y_second, f.z_second);
    if (f.cur_count == CNT_ONE || f.cur_count == CNT_TWO)
      place_contact(f.id_first, f.x_first, f.y_first, f.z_first);
    if (f.cur_count == CNT_ZERO) begin
      track_slots[0].valid = 1'b0;
      track_slots[1].valid = 1'b0;
    end

    r1 = make_rec(1'b1, 1'b1, track_slots[1].x, track_slots[1].y,
                  track_slots[1].z[Z_W-1:1], 1'b0, 1'b0, 1'b0);
    if (report_mode_q == MODE_PER_SLOT) begin
      if (track_slots[0].valid) begin
        r0 = make_rec(1'b0, 1'b1, track_slots[0].x, track_slots[0].y,
                      track_slots[0].z[Z_W-1:1], 1'b1, 1'b1, 1'b1);
        has_two = track_slots[1].valid;
      end else if (track_slots[1].valid) begin
        r0 = r1;
        has_two = 1'b0;
      end else begin
        r0 = make_rec(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        has_two = 1'b0;
      end
    end else begin
      r0 = make_rec(1'b0, 1'b1, track_slots[0].x, track_slots[0].y,
                    track_slots[0].valid ? track_slots[0].z[Z_W-1:1] : '0,
                    1'b1, track_slots[0].valid, track_slots[1].valid);
      has_two = track_slots[1].valid;
    end

    if (has_two) begin
      r1.last = 1'b1;
      expected_recs.push_back(r0);
      expected_recs.push_back(r1);
    end else begin
      r0.last = 1'b1;
      expected_recs.push_back(r0);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_record();
    rec_t want;
    if (expected_recs.size() == 0) begin
      $error("record transaction on out_ch with no frame waiting for it");
      mismatches++;
    end else begin
      want = expected_recs.pop_front();
      check_field("slot_index", 32'(want.slot_index), 32'(out_ch.slot_index));
      check_field("has_contact", 32'(want.has_contact), 32'(out_ch.has_contact));
      check_field("pos_x", 32'(want.pos_x), 32'(out_ch.pos_x));
      check_field("pos_y", 32'(want.pos_y), 32'(out_ch.pos_y));
      check_field("major", 32'(want.major), 32'(out_ch.major));
      check_field("buttons_present", 32'(want.buttons_present),
                  32'(out_ch.buttons_present));
      check_field("button_touch", 32'(want.button_touch), 32'(out_ch.button_touch));
      check_field("button_second", 32'(want.button_second), 32'(out_ch.button_second));
      check_field("last", 32'(want.last), 32'(out_ch.last));
    end
  endfunction

  always @(posedge clk) begin
    frame_t f;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        check_record();
      if (cfg_ch.valid && cfg_ch.ready)
        report_mode_q = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        f.prev_count = in_ch.prev_count;
        f.cur_count  = in_ch.cur_count;
        f.id_first   = in_ch.id_first;
        f.x_first    = in_ch.x_first;
        f.y_first    = in_ch.y_first;
        f.z_first    = in_ch.z_first;
        f.id_second  = in_ch.id_second;
        f.x_second   = in_ch.x_second;
        f.y_second   = in_ch.y_second;
        f.z_second   = in_ch.z_second;
        predict_frame(f);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_ch.ready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_frame(input frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.prev_count <= f.prev_count;
    in_ch.cur_count  <= f.cur_count;
    in_ch.id_first   <= f.id_first;
    in_ch.x_first    <= f.x_first;
    in_ch.y_first    <= f.y_first;
    in_ch.z_first    <= f.z_first;
    in_ch.id_second  <= f.id_second;
    in_ch.x_second   <= f.x_second;
    in_ch.y_second   <= f.y_second;
    in_ch.z_second   <= f.z_second;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= mode;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic next_random_frame(output frame_t f);
    logic [ID_W-1:0] id_swap;
    f.x_first  = COORD_W'($urandom_range(4095));
    f.y_first  = COORD_W'($urandom_range(4095));
    f.z_first  = Z_W'($urandom_range(255));
    f.x_second = COORD_W'($urandom_range(4095));
    f.y_second = COORD_W'($urandom_range(4095));
    f.z_second = Z_W'($urandom_range(255));
    if ($urandom_range(99) < 82) begin
      f.prev_count = gen_count;
      f.cur_count  = CNT_W'($urandom_range(2));
      f.id_first   = ($urandom_range(3) == 0) ? ID_W'($urandom_range(15)) : gen_ids[0];
      f.id_second  = ($urandom_range(3) == 0) ? ID_W'($urandom_range(15)) : gen_ids[1];
      if ($urandom_range(4) == 0) begin
        id_swap     = f.id_first;
        f.id_first  = f.id_second;
        f.id_second = id_swap;
      end
    end else begin
      f.prev_count = CNT_W'($urandom_range(3));
      f.cur_count  = CNT_W'($urandom_range(3));
      f.id_first   = ID_W'($urandom_range(15));
      f.id_second  = ID_W'($urandom_range(15));
    end
    if (f.cur_count != CNT_BAD)
      gen_count = f.cur_count;
    gen_ids[0] = f.id_first;
    gen_ids[1] = f.id_second;
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int frames);
    frame_t f;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (frames) begin
      next_random_frame(f);
      send_frame(f);
    end
    wait_idle();
  endtask

  task automatic test_per_slot_frames();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_mode(MODE_PER_SLOT);
    send_frame(mk_frame(CNT_ZERO, CNT_ZERO, 0, 0, 0, 0, 0, 0, 0, 0));
    send_frame(mk_frame(CNT_ZERO, CNT_ONE, 0, 4095, 0, 255, 0, 0, 0, 0));
    send_frame(mk_frame(CNT_ONE, CNT_TWO, 0, 0, 4095, 1, 15, 4095, 4095, 254));
    send_frame(mk_frame(CNT_TWO, CNT_ONE, 15, 100, 200, 30, 0, 4095, 4095, 255));
    send_frame(mk_frame(CNT_TWO, CNT_ONE, 7, 1, 2, 3, 9, 4, 5, 6));
    send_frame(mk_frame(CNT_ONE, CNT_TWO, 7, 10, 20, 40, 3, 30, 40, 50));
    send_frame(mk_frame(CNT_BAD, CNT_TWO, 5, 2730, 1365, 170, 6, 1365, 2730, 85));
    send_frame(mk_frame(CNT_TWO, CNT_BAD, 1, 11, 22, 33, 2, 44, 55, 66));
    send_frame(mk_frame(CNT_ZERO, CNT_ZERO, 1, 11, 22, 33, 2, 44, 55, 66));
    send_frame(mk_frame(CNT_ZERO, CNT_BAD, 8, 99, 98, 97, 8, 96, 95, 94));
    wait_idle();
  endtask

  task automatic test_fixed_frames();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_mode(MODE_FIXED);
    send_frame(mk_frame(CNT_ZERO, CNT_ZERO, 0, 0, 0, 0, 0, 0, 0, 0));
    send_frame(mk_frame(CNT_ZERO, CNT_ONE, 4, 4095, 4095, 255, 0, 0, 0, 0));
    send_frame(mk_frame(CNT_ONE, CNT_TWO, 4, 300, 301, 120, 4, 400, 401, 121));
    send_frame(mk_frame(CNT_ONE, CNT_TWO, 4, 310, 311, 122, 11, 500, 501, 7));
    send_frame(mk_frame(CNT_TWO, CNT_TWO, 11, 520, 521, 9, 4, 320, 321, 124));
    send_frame(mk_frame(CNT_TWO, CNT_ONE, 12, 600, 601, 200, 13, 700, 701, 201));
    send_frame(mk_frame(CNT_ONE, CNT_ZERO, 12, 0, 0, 0, 13, 0, 0, 0));
    send_frame(mk_frame(CNT_ONE, CNT_ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_frame(mk_frame(CNT_TWO, CNT_TWO, 15, 4095, 0, 255, 14, 0, 4095, 0));
    send_frame(mk_frame(CNT_BAD, CNT_BAD, 15, 1, 1, 1, 14, 2, 2, 2));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic mode;
    for (int m = 0; m < 2; m++) begin
      mode = (m == 0) ? MODE_PER_SLOT : MODE_FIXED;
      write_mode(mode);
      run_random_phase(0, 0, PHASE_FRAMES);
      run_random_phase(88, 0, PHASE_FRAMES);
      run_random_phase(0, 88, PHASE_FRAMES);
      run_random_phase(9, 9, PHASE_FRAMES);
    end
  endtask

  task automatic test_output_hold();
    frame_t f;
    write_mode(MODE_FIXED);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len = HOLD_CYCLES;
    repeat (12) begin
      next_random_frame(f);
      send_frame(f);
    end
    wait_idle();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.prev_count = '0;
    in_ch.cur_count  = '0;
    in_ch.id_first   = '0;
    in_ch.x_first    = '0;
    in_ch.y_first    = '0;
    in_ch.z_first    = '0;
    in_ch.id_second  = '0;
    in_ch.x_second   = '0;
    in_ch.y_second   = '0;
    in_ch.z_second   = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = 1'b0;
    report_mode_q    = MODE_PER_SLOT;
    track_slots[0]   = '0;
    track_slots[1]   = '0;
    mismatches       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_len         = 0;
    gen_count        = CNT_ZERO;
    gen_ids[0]       = '0;
    gen_ids[1]       = 4'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_per_slot_frames();
    test_fixed_frames();
    test_random_traffic();
    test_output_hold();
    write_mode(MODE_PER_SLOT);
    wait_idle();

    if (mismatches == 0 && expected_recs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
